// ----- hdl/rlsd_pkg.sv -----
// ----------------------------------------------------------------------------
// rlsd_pkg
// Shared types and constants of the RGB LED serial driver.
// ----------------------------------------------------------------------------
package rlsd_pkg;

	// Register indexes on the configuration port
	localparam logic [1:0] CFG_INTENSITY  = 2'd0;
	localparam logic [1:0] CFG_ZERO_HIGH  = 2'd1;
	localparam logic [1:0] CFG_ONE_HIGH   = 2'd2;
	localparam logic [1:0] CFG_BIT_PERIOD = 2'd3;

	// Item codes
	localparam logic OP_TICK = 1'b0;
	localparam logic OP_LOAD = 1'b1;

	// Intensity scaling: x / 100 as (x * 5243) >> 19, exact for x <= 25500
	localparam logic [6:0]  PCT_MAX     = 7'd100;
	localparam logic [12:0] RECIP_100   = 13'd5243;
	localparam int          RECIP_SHIFT = 19;

	// Color bits carried by one GRB word
	localparam int COLOR_BITS = 24;

	// Depth of the queue between front and back
	localparam int QUEUE_DEPTH = 2;

	typedef struct packed {
		logic [6:0] intensity;
		logic [7:0] zero_high;
		logic [7:0] one_high;
		logic [7:0] bit_period;
	} cfg_t;

	// Classified item: op plus already scaled channels
	typedef struct packed {
		logic       op;
		logic [7:0] green;
		logic [7:0] red;
		logic [7:0] blue;
	} item_t;

endpackage

// ----- hdl/rlsd_front.sv -----
// ----------------------------------------------------------------------------
// rlsd_front
// Accepts items, scales the color channels by the intensity percentage.
// ----------------------------------------------------------------------------
module rlsd_front
	import rlsd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic [6:0] intensity,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       op,
	input  logic [7:0] red,
	input  logic [7:0] green,
	input  logic [7:0] blue,
	input  logic       q_full,
	output logic       push,
	output item_t      push_item
);

	logic        valid_s1;
	logic        op_s1;
	logic [14:0] prod_g_s1;
	logic [14:0] prod_r_s1;
	logic [14:0] prod_b_s1;
	logic [6:0]  pct;
	logic [27:0] quot_g;
	logic [27:0] quot_r;
	logic [27:0] quot_b;

	assign pct      = (intensity > PCT_MAX) ? PCT_MAX : intensity;
	assign in_ready = !valid_s1 || !q_full;
	assign push     = valid_s1 && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Stage 1: channel times percentage
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			op_s1     <= op;
			prod_g_s1 <= 15'(green * pct);
			prod_r_s1 <= 15'(red * pct);
			prod_b_s1 <= 15'(blue * pct);
		end
	end

	// Divide by 100 through the reciprocal
	assign quot_g = 28'(prod_g_s1 * RECIP_100);
	assign quot_r = 28'(prod_r_s1 * RECIP_100);
	assign quot_b = 28'(prod_b_s1 * RECIP_100);

	always_comb begin
		push_item.op    = op_s1;
		push_item.green = quot_g[RECIP_SHIFT +: 8];
		push_item.red   = quot_r[RECIP_SHIFT +: 8];
		push_item.blue  = quot_b[RECIP_SHIFT +: 8];
	end

endmodule

// ----- hdl/rlsd_queue.sv -----
// ----------------------------------------------------------------------------
// rlsd_queue
// Short FIFO of classified items between front and back.
// ----------------------------------------------------------------------------
module rlsd_queue
	import rlsd_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	input  logic  pop,
	output item_t pop_item,
	output logic  full,
	output logic  empty
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	item_t             mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign full     = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign pop_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// ----- hdl/rlsd_back.sv -----
// ----------------------------------------------------------------------------
// rlsd_back
// Runs the bit waveform state and holds the result register.
// ----------------------------------------------------------------------------
module rlsd_back
	import rlsd_pkg::*;
#(
	parameter int BITS_PER_LED = 24
)
(
	input  logic  clk,
	input  logic  arst_n,
	input  cfg_t  cfg,
	input  logic  empty,
	input  item_t pop_item,
	output logic  pop,
	output logic  out_valid,
	input  logic  out_ready,
	output logic  data_pin,
	output logic  busy_res,
	output logic  rejected,
	output logic  frame_done
);

	localparam int BL_W = $clog2(BITS_PER_LED + 1);
	localparam int PAD  = BITS_PER_LED - COLOR_BITS;

	logic [BITS_PER_LED-1:0] shift_bits_q;
	logic [BL_W-1:0]         bits_left_q;
	logic [7:0]              phase_count_q;
	logic                    sending_q;

	logic [BITS_PER_LED-1:0] shift_d;
	logic [BL_W-1:0]         bits_left_d;
	logic [7:0]              phase_d;
	logic                    sending_d;
	logic                    pin_d;
	logic                    rej_d;
	logic                    done_d;
	logic [8:0]              phase_inc;
	logic                    out_valid_q;

	// Pin level from a given state
	function automatic logic level(input logic snd, input logic top, input logic [7:0] ph,
		input cfg_t c);
		logic [7:0] high;
		high = top ? c.one_high : c.zero_high;
		return snd && (ph < high);
	endfunction

	assign out_valid = out_valid_q;
	assign pop       = !empty && (!out_valid_q || out_ready);
	assign phase_inc = {1'b0, phase_count_q} + 9'd1;

	always_comb begin
		shift_d     = shift_bits_q;
		bits_left_d = bits_left_q;
		phase_d     = phase_count_q;
		sending_d   = sending_q;
		pin_d       = 1'b0;
		rej_d       = 1'b0;
		done_d      = 1'b0;
		if (pop_item.op == OP_LOAD) begin
			if (sending_q) begin
				rej_d = 1'b1;
				pin_d = level(sending_q, shift_bits_q[BITS_PER_LED-1], phase_count_q, cfg);
			end else begin
				shift_d     = BITS_PER_LED'({pop_item.green, pop_item.red, pop_item.blue})
					<< PAD;
				bits_left_d = BL_W'(BITS_PER_LED);
				phase_d     = '0;
				sending_d   = 1'b1;
				pin_d       = level(1'b1, pop_item.green[7], 8'd0, cfg);
			end
		end else if (sending_q) begin
			pin_d = level(1'b1, shift_bits_q[BITS_PER_LED-1], phase_count_q, cfg);
			if (phase_inc >= {1'b0, cfg.bit_period}) begin
				phase_d     = '0;
				shift_d     = shift_bits_q << 1;
				bits_left_d = bits_left_q - 1'b1;
				if (bits_left_q == BL_W'(1)) begin
					sending_d = 1'b0;
					done_d    = 1'b1;
				end
			end else begin
				phase_d = phase_inc[7:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_bits_q  <= '0;
			bits_left_q   <= '0;
			phase_count_q <= '0;
			sending_q     <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (pop) begin
				shift_bits_q  <= shift_d;
				bits_left_q   <= bits_left_d;
				phase_count_q <= phase_d;
				sending_q     <= sending_d;
				out_valid_q   <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			data_pin   <= pin_d;
			busy_res   <= sending_d;
			rejected   <= rej_d;
			frame_done <= done_d;
		end
	end

endmodule

// ----- hdl/rgb_led_serial_driver.sv -----
// ----------------------------------------------------------------------------
// rgb_led_serial_driver
// Single-wire RGB LED encoder: scales a color, sends it GRB, MSB first.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): each transaction is one item. op selects
//   a tick (one clock of the LED waveform) or a color load (red, green, blue).
//   Output channel (out_valid/out_ready): exactly one result transaction per
//   item, in order: data_pin, busy_res, rejected, frame_done.
//   Configuration: cfg_we writes cfg_wdata to register cfg_index (0 intensity
//   percent, 1 zero-bit high ticks, 2 one-bit high ticks, 3 bit period).
//   Write only while no item is in flight.
// Pipeline and throughput:
//   An item passes the stage register (scaling multiply, loaded on the
//   accepting edge), the queue (reciprocal divide) and the result register
//   (waveform state update). One item per cycle is sustained while out_ready
//   stays high; the back end updates the waveform state once per popped item.
// Reset: arst_n clears the waveform state to idle and empties the pipeline;
//   registers return to 100 percent, 17, 34 and 60 ticks.
// Stall: when out_ready is low the result register holds, the back end
//   stops, the two-entry queue fills and then in_ready drops.
// ----------------------------------------------------------------------------
module rgb_led_serial_driver
	import rlsd_pkg::*;
#(
	parameter int BITS_PER_LED = 24
)
(
	input  logic       clk,
	input  logic       arst_n,
	// configuration write port
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_wdata,
	// input transactions
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       op,
	input  logic [7:0] red,
	input  logic [7:0] green,
	input  logic [7:0] blue,
	// result transactions
	output logic       out_valid,
	input  logic       out_ready,
	output logic       data_pin,
	output logic       busy_res,
	output logic       rejected,
	output logic       frame_done
);

	cfg_t  cfg_q;
	logic  q_full;
	logic  q_empty;
	logic  push;
	logic  pop;
	item_t push_item;
	item_t pop_item;

	// Configuration registers; write them only while idle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.intensity  <= 7'd100;
			cfg_q.zero_high  <= 8'd17;
			cfg_q.one_high   <= 8'd34;
			cfg_q.bit_period <= 8'd60;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_INTENSITY:  cfg_q.intensity  <= cfg_wdata[6:0];
				CFG_ZERO_HIGH:  cfg_q.zero_high  <= cfg_wdata;
				CFG_ONE_HIGH:   cfg_q.one_high   <= cfg_wdata;
				CFG_BIT_PERIOD: cfg_q.bit_period <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Front: accept and scale
	rlsd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.intensity (cfg_q.intensity),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.op        (op),
		.red       (red),
		.green     (green),
		.blue      (blue),
		.q_full    (q_full),
		.push      (push),
		.push_item (push_item)
	);

	// Decouple front from back
	rlsd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.pop_item  (pop_item),
		.full      (q_full),
		.empty     (q_empty)
	);

	// Back: waveform state and result register
	rlsd_back #(
		.BITS_PER_LED (BITS_PER_LED)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.empty      (q_empty),
		.pop_item   (pop_item),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.data_pin   (data_pin),
		.busy_res   (busy_res),
		.rejected   (rejected),
		.frame_done (frame_done)
	);

endmodule

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the RGB LED serial driver. A cycle-level model of
// the waveform encoder predicts one pin sample per item; every result
// transaction is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
	import rlsd_pkg::*;

	// Receiver hold-off used to fill the pipeline and stall the input side
	localparam int HOLD_CYCLES     = 48;
	// Cycles to wait after the last result before touching registers or ending
	localparam int SETTLE_CYCLES   = 6;
	// Watchdog: cycles with no transaction on either side
	localparam int STALL_LIMIT     = 500;
	localparam int RANDOM_ROUNDS   = 8;
	localparam int ITEMS_PER_ROUND = 67;
	localparam int MAX_REPORTS     = 20;
	// Rate at which each side inserts idle cycles, in percent
	localparam int IDLE_PERCENT    = 29;

	// One predicted result: the four output fields of a result transaction
	typedef struct packed {
		logic pin;
		logic busy;
		logic dropped;
		logic done;
	} pin_sample_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	logic [1:0] cfg_index = CFG_INTENSITY;
	logic [7:0] cfg_wdata = '0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic       op = OP_TICK;
	logic [7:0] red = '0;
	logic [7:0] green = '0;
	logic [7:0] blue = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic       data_pin;
	logic       busy_res;
	logic       rejected;
	logic       frame_done;

	// Stimulus control: burst_mode drops idling on both sides; each toggle of
	// hold_req_tgl asks the receiver for one long hold-off
	logic       burst_mode = 1'b0;
	logic       hold_req_tgl = 1'b0;
	logic       hold_ack_tgl = 1'b0;
	int         hold_left = 0;

	int         err_count = 0;

	// Pin samples predicted for accepted items, oldest first
	pin_sample_t pending_samples[$];

	// Encoder model: register copies and waveform state, at reset values
	logic [6:0]  scale_pct = 7'd100;
	logic [7:0]  zero_ticks = 8'd17;
	logic [7:0]  one_ticks = 8'd34;
	logic [7:0]  period_ticks = 8'd60;
	logic [23:0] wf_shift = '0;
	logic [4:0]  wf_bits_left = '0;
	logic [7:0]  wf_phase = '0;
	logic        wf_sending = 1'b0;

	rgb_led_serial_driver u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.op         (op),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.data_pin   (data_pin),
		.busy_res   (busy_res),
		.rejected   (rejected),
		.frame_done (frame_done)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Encoder model
	// ------------------------------------------------------------------------

	// Scale one channel by the intensity, clamping the percentage at 100
	function automatic logic [7:0] scale_channel(input logic [7:0] level);
		int unsigned pct;
		int unsigned scaled;
		pct = (scale_pct > PCT_MAX) ? PCT_MAX : scale_pct;
		scaled = (level * pct) / 100;
		return scaled[7:0];
	endfunction

	// Level the pin carries at the current phase of the current bit
	function automatic logic pin_level();
		logic [7:0] high_ticks;
		if (!wf_sending)
			return 1'b0;
		high_ticks = wf_shift[COLOR_BITS-1] ? one_ticks : zero_ticks;
		return wf_phase < high_ticks;
	endfunction

	// Apply one item to the model and return the result it must produce
	function automatic pin_sample_t advance_waveform(input logic item_op,
			input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
		pin_sample_t sample;
		logic [8:0]  next_phase;
		sample = '0;
		if (item_op == OP_LOAD) begin
			// A load during a frame is dropped and leaves the frame alone
			if (wf_sending) begin
				sample.dropped = 1'b1;
			end else begin
				wf_shift = {scale_channel(g), scale_channel(r), scale_channel(b)};
				wf_bits_left = 5'd24;
				wf_phase = '0;
				wf_sending = 1'b1;
			end
			sample.pin = pin_level();
		end else if (wf_sending) begin
			// Tick: drive the current level, then step the bit timer
			sample.pin = pin_level();
			next_phase = {1'b0, wf_phase} + 9'd1;
			if (next_phase >= {1'b0, period_ticks}) begin
				wf_phase = '0;
				wf_shift = wf_shift << 1;
				if (wf_bits_left != 0)
					wf_bits_left = wf_bits_left - 5'd1;
				if (wf_bits_left == 0) begin
					wf_sending = 1'b0;
					sample.done = 1'b1;
				end
			end else begin
				wf_phase = next_phase[7:0];
			end
		end
		sample.busy = wf_sending;
		return sample;
	endfunction

	// ------------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------------

	// Offer one item, hold it until the transaction completes, then predict
	task automatic send_item(input logic item_op, input logic [7:0] r,
			input logic [7:0] g, input logic [7:0] b);
		while (!burst_mode && $urandom_range(99) < IDLE_PERCENT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		op <= item_op;
		red <= r;
		green <= g;
		blue <= b;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		pending_samples.push_back(advance_waveform(item_op, r, g, b));
	endtask

	// Ticks carry random colors, which the block must ignore
	task automatic send_tick();
		send_item(OP_TICK, 8'($urandom_range(255)), 8'($urandom_range(255)),
			8'($urandom_range(255)));
	endtask

	// Keep ticking until the model says the current frame is out
	task automatic finish_frame();
		while (wf_sending)
			send_tick();
	endtask

	// Drop valid and wait until every predicted result has come back
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_samples.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] index, input logic [7:0] word);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_wdata <= word;
		@(posedge clk);
		case (index)
			CFG_INTENSITY:  scale_pct = word[6:0];
			CFG_ZERO_HIGH:  zero_ticks = word;
			CFG_ONE_HIGH:   one_ticks = word;
			CFG_BIT_PERIOD: period_ticks = word;
			default: ;
		endcase
	endtask

	// Write all four registers back to back; call only while idle
	task automatic write_regs(input logic [7:0] pct_word, input logic [7:0] zero_word,
			input logic [7:0] one_word, input logic [7:0] period_word);
		write_reg(CFG_INTENSITY, pct_word);
		write_reg(CFG_ZERO_HIGH, zero_word);
		write_reg(CFG_ONE_HIGH, one_word);
		write_reg(CFG_BIT_PERIOD, period_word);
		cfg_we <= 1'b0;
	endtask

	// Random channel value, biased toward the extremes
	function automatic logic [7:0] pick_level();
		case ($urandom_range(4))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// Receiver: random ready, plus a long hold-off on request
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (hold_req_tgl != hold_ack_tgl) begin
			hold_ack_tgl <= hold_req_tgl;
			hold_left <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= burst_mode || ($urandom_range(99) >= IDLE_PERCENT);
		end
	end

	// ------------------------------------------------------------------------
	// Result checking
	// ------------------------------------------------------------------------
	task automatic compare_field(input string field, input logic want, input logic got);
		if (got !== want) begin
			err_count++;
			if (err_count <= MAX_REPORTS)
				$display("%0t: %s mismatch, expected %0b, got %0b", $time, field, want, got);
		end
	endtask

	always @(posedge clk) begin : result_check
		pin_sample_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_samples.size() == 0) begin
				err_count++;
				if (err_count <= MAX_REPORTS)
					$display("%0t: unexpected result, expected none, got %0b%0b%0b%0b",
						$time, data_pin, busy_res, rejected, frame_done);
			end else begin
				want = pending_samples.pop_front();
				compare_field("data_pin", want.pin, data_pin);
				compare_field("busy_res", want.busy, busy_res);
				compare_field("rejected", want.dropped, rejected);
				compare_field("frame_done", want.done, frame_done);
			end
		end
	end

	// Watchdog: end the run if nothing moves on either channel for too long
	initial begin
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("TEST FAILED");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Ticks with no frame pending keep the pin low and change nothing
	task automatic test_idle_ticks();
		repeat (3) send_tick();
	endtask

	// Start a frame at reset settings, then try to load over it
	task automatic test_load_while_busy();
		send_item(OP_LOAD, 8'hFF, 8'hFF, 8'hFF);
		repeat (3) send_tick();
		send_item(OP_LOAD, 8'h0F, 8'hF0, 8'h00);
		send_tick();
	endtask

	// Corner timings: full-high and full-low bits, one-tick and zero-tick
	// periods, clamped intensity and zero intensity
	task automatic test_timing_extremes();
		// Intensity word 0xFF gives 127, clamped to 100; zero bits all low,
		// one bits all high; the frame left from before finishes here
		drain_results();
		write_regs(8'hFF, 8'd0, 8'd255, 8'd1);
		finish_frame();
		send_item(OP_LOAD, 8'hC8, 8'h11, 8'h63);
		finish_frame();

		// Zero intensity blanks any color; period zero still takes one tick
		drain_results();
		write_regs(8'h00, 8'd1, 8'd1, 8'd0);
		send_item(OP_LOAD, 8'hFF, 8'hFF, 8'hFF);
		finish_frame();

		// Short period with a one bit high for the whole period
		drain_results();
		write_regs(8'd100, 8'd1, 8'd2, 8'd2);
		send_item(OP_LOAD, 8'hA5, 8'h5A, 8'h3C);
		repeat (5) send_tick();
		send_item(OP_LOAD, 8'h01, 8'h02, 8'h03);
		finish_frame();
	endtask

	// Hold off the receiver while items keep coming so in_ready drops, then
	// pause the sender until the pipeline is empty
	task automatic test_output_stall();
		drain_results();
		write_regs(8'd50, 8'd2, 8'd5, 8'd6);
		hold_req_tgl <= ~hold_req_tgl;
		send_item(OP_LOAD, 8'h80, 8'h7F, 8'hC3);
		repeat (30) send_tick();
		send_item(OP_LOAD, 8'h55, 8'hAA, 8'h01);
		drain_results();
	endtask

	// Rounds of random settings, each driving loads followed by tick runs,
	// with stray loads during frames and idle ticks between them
	task automatic test_random_frames();
		logic [7:0] pct_word;
		logic [7:0] zero_word;
		logic [7:0] one_word;
		logic [7:0] period_word;
		logic       item_op;
		for (int round = 0; round < RANDOM_ROUNDS; round++) begin
			drain_results();
			case ($urandom_range(9))
				0, 1: period_word = 8'd0;
				2, 3: period_word = 8'd1;
				4:    period_word = 8'd255;
				default: period_word = 8'($urandom_range(4, 2));
			endcase
			zero_word = ($urandom_range(9) == 0) ? 8'd255 :
				8'($urandom_range(period_word + 1));
			one_word = ($urandom_range(9) == 0) ? 8'd255 :
				8'($urandom_range(period_word + 1));
			pct_word = 8'($urandom_range(255));
			write_regs(pct_word, zero_word, one_word, period_word);
			// One round runs with no idling on either side
			burst_mode <= (round == 3);
			for (int n = 0; n < ITEMS_PER_ROUND; n++) begin
				if (wf_sending)
					item_op = ($urandom_range(99) < 6) ? OP_LOAD : OP_TICK;
				else
					item_op = ($urandom_range(99) < 70) ? OP_LOAD : OP_TICK;
				send_item(item_op, pick_level(), pick_level(), pick_level());
			end
		end
		burst_mode <= 1'b0;
	endtask

	// ------------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------------
	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_idle_ticks();
		test_load_while_busy();
		test_timing_extremes();
		test_output_stall();
		test_random_frames();
		drain_results();
		if (err_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ----- filelist.f -----
hdl/rlsd_pkg.sv
hdl/rlsd_front.sv
hdl/rlsd_queue.sv
hdl/rlsd_back.sv
hdl/rgb_led_serial_driver.sv
bench/testbench.sv
